@@ design/shabsh_pkg.sv @@
`default_nettype none

package shabsh_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned ROUNDS       = 64;
   localparam int unsigned DIGEST_WORDS = 8;
   localparam int unsigned TOTAL_W      = 61;

   typedef logic [WORD_W-1:0] word_type;

   localparam logic [5:0] ROUND_LAST  = 6'(ROUNDS - 1);
   localparam logic [2:0] DIGEST_LAST = 3'(DIGEST_WORDS - 1);
   localparam logic [5:0] BLOCK_FULL  = 6'd63;
   localparam logic [5:0] LEN_START   = 6'd56;
   localparam logic [7:0] PAD_MARK    = 8'h80;

   localparam word_type INIT_HASH [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_CLEAR,
      ST_LEN,
      ST_INIT,
      ST_ROUND,
      ST_UPDATE,
      ST_SEND
   } state_type;

   // What follows once a compression finishes.
   typedef enum logic [1:0] {
      AFTER_DATA,
      AFTER_PAD,
      AFTER_FINAL
   } after_type;

   typedef struct packed {
      logic       load_byte;
      logic       pad;
      logic       clear;
      logic       load_len;
      logic       init;
      logic       round;
      logic [5:0] k_idx;
      logic       update;
      logic       rotate;
      logic       restart;
   } cmd_type;

   typedef struct packed {
      logic block_full;
      logic pad_two;
   } status_type;

   function automatic word_type rotr(input word_type v, input int unsigned n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic word_type big_sig0(input word_type v);
      return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic word_type big_sig1(input word_type v);
      return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic word_type small_sig0(input word_type v);
      return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type v);
      return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

@@ design/shabsh_ctrl.sv @@
`default_nettype none

module shabsh_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_byte_present,
   input  wire logic                   req_message_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_digest_last,
   input  wire shabsh_pkg::status_type status,
   output shabsh_pkg::cmd_type         cmd
);
   import shabsh_pkg::*;

   state_type  state_ff, state_in;
   after_type  after_ff, after_in;
   logic       last_pend_ff, last_pend_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      last_pend_in = last_pend_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_pend_in = req_message_end;
               if (req_byte_present && status.block_full) begin
                  after_in = AFTER_DATA;
                  state_in = ST_INIT;
               end else if (req_message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Marker landed too late for the length field: one extra block.
            if (status.pad_two) begin
               after_in = AFTER_PAD;
               state_in = ST_INIT;
            end else begin
               state_in = ST_LEN;
            end
         end
         ST_CLEAR: begin
            state_in = ST_LEN;
         end
         ST_LEN: begin
            after_in = AFTER_FINAL;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            unique case (after_ff)
               AFTER_DATA:  state_in = last_pend_ff ? ST_PAD : ST_IDLE;
               AFTER_PAD:   state_in = ST_CLEAR;
               AFTER_FINAL: begin
                  cnt_in   = '0;
                  state_in = ST_SEND;
               end
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_SEND: begin
            if (rsp_ready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == DIGEST_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      rsp_valid       = (state_ff == ST_SEND);
      rsp_digest_last = rsp_valid && (cnt_ff[2:0] == DIGEST_LAST);
      cmd.load_byte   = req_ready && req_valid && req_byte_present;
      cmd.pad         = (state_ff == ST_PAD);
      cmd.clear       = (state_ff == ST_CLEAR);
      cmd.load_len    = (state_ff == ST_LEN);
      cmd.init        = (state_ff == ST_INIT);
      cmd.round       = (state_ff == ST_ROUND);
      cmd.k_idx       = cnt_ff;
      cmd.update      = (state_ff == ST_UPDATE);
      cmd.rotate      = rsp_valid && rsp_ready;
      cmd.restart     = rsp_digest_last && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= AFTER_DATA;
         last_pend_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         last_pend_ff <= last_pend_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ design/shabsh_dp.sv @@
`default_nettype none

module shabsh_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire shabsh_pkg::cmd_type cmd,
   input  wire logic [7:0]          data_byte,
   output shabsh_pkg::status_type   status,
   output shabsh_pkg::word_type     digest_word
);
   import shabsh_pkg::*;

   // The block buffer doubles as the rolling message schedule window.
   word_type           win_ff   [BLOCK_WORDS];
   word_type           win_in   [BLOCK_WORDS];
   word_type           var_ff   [DIGEST_WORDS];
   word_type           var_in   [DIGEST_WORDS];
   word_type           chain_ff [DIGEST_WORDS];
   word_type           chain_in [DIGEST_WORDS];
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [5:0] pos;
   logic [1:0] lane;
   word_type   sched_new;
   word_type   t1;
   word_type   t2;
   word_type   ch;
   word_type   maj;

   assign pos  = total_ff[5:0];
   assign lane = ~pos[1:0];

   assign sched_new = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + big_sig1(var_ff[4]) + ch + round_k(cmd.k_idx) + win_ff[0];
   assign t2  = big_sig0(var_ff[0]) + maj;

   always_comb begin
      logic [5:0] pidx;
      pidx     = '0;
      win_in   = win_ff;
      var_in   = var_ff;
      chain_in = chain_ff;
      total_in = total_ff;

      if (cmd.load_byte) begin
         win_in[pos[5:2]][{lane, 3'b000} +: 8] = data_byte;
         total_in = total_ff + TOTAL_W'(1);
      end

      if (cmd.pad) begin
         for (int w = 0; w < BLOCK_WORDS; w++) begin
            for (int l = 0; l < 4; l++) begin
               pidx = 6'(w * 4 + l);
               if (pidx == pos) begin
                  win_in[w][8*(3-l) +: 8] = PAD_MARK;
               end else if (pidx > pos) begin
                  win_in[w][8*(3-l) +: 8] = 8'h00;
               end
            end
         end
      end

      if (cmd.clear) begin
         for (int w = 0; w < BLOCK_WORDS; w++) begin
            win_in[w] = '0;
         end
      end

      if (cmd.load_len) begin
         win_in[BLOCK_WORDS-2] = total_ff[TOTAL_W-1:TOTAL_W-WORD_W];
         win_in[BLOCK_WORDS-1] = {total_ff[TOTAL_W-WORD_W-1:0], 3'b000};
      end

      if (cmd.init) begin
         var_in = chain_ff;
      end

      if (cmd.round) begin
         for (int w = 0; w < BLOCK_WORDS - 1; w++) begin
            win_in[w] = win_ff[w+1];
         end
         win_in[BLOCK_WORDS-1] = sched_new;
         for (int v = DIGEST_WORDS - 1; v > 0; v--) begin
            var_in[v] = var_ff[v-1];
         end
         var_in[4] = var_ff[3] + t1;
         var_in[0] = t1 + t2;
      end

      if (cmd.update) begin
         for (int v = 0; v < DIGEST_WORDS; v++) begin
            chain_in[v] = chain_ff[v] + var_ff[v];
         end
      end

      if (cmd.rotate) begin
         for (int v = 0; v < DIGEST_WORDS - 1; v++) begin
            chain_in[v] = chain_ff[v+1];
         end
         chain_in[DIGEST_WORDS-1] = chain_ff[0];
      end

      if (cmd.restart) begin
         chain_in = INIT_HASH;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
         total_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      var_ff <= var_in;
   end

   assign status.block_full = (pos == BLOCK_FULL);
   assign status.pad_two    = (pos >= LEN_START);
   assign digest_word       = chain_ff[0];

endmodule

`default_nettype wire

@@ design/sha256_byte_stream_hasher_unit.sv @@
`default_nettype none

// Channel    Direction  Handshake              Payload
// req_       in         req_valid/req_ready    data_byte, byte_present, message_end
// rsp_       out        rsp_valid/rsp_ready    digest_word, digest_last
//
// A byte that does not complete a block is taken while the unit stays idle.
// A byte that fills the 64th slot starts a compression: load, 64 rounds of the
// single round unit, and the chaining update.
// The end of a message pads and compresses the final block, with one more
// block when the length does not fit, then sends one word per cycle of rsp_ready.
// Reset returns to idle with the initial hash values and a zero byte count.
// No new transaction is taken while a block compresses or a digest is out.
module sha256_byte_stream_hasher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_message_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_digest_last
);
   import shabsh_pkg::*;

   cmd_type    cmd;
   status_type status;

   shabsh_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_last  (rsp_digest_last),
      .status           (status),
      .cmd              (cmd)
   );

   shabsh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire

@@ design/shabsh_checker.sv @@
`default_nettype none

module shabsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_message_end,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic        rsp_digest_last
);

   // Input and output never overlap: a digest drains before the next byte.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                  && $stable(rsp_digest_last))
      else $error("stalled digest word changed");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_digest_last |=> !rsp_valid)
      else $error("digest continued after its last word");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_message_end |=> !rsp_valid)
      else $error("digest started without a message end");

endmodule

bind sha256_byte_stream_hasher_unit shabsh_checker u_shabsh_checker (.*);

`default_nettype wire

@@ test/sha256_byte_stream_hasher_unit_test.sv @@
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit_test;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int TOTAL_ITEMS  = 170;
   localparam int DRAIN_CYCLES = 160;
   localparam int IDLE_LIMIT   = 4000;

   typedef logic [31:0] word_type;

   typedef struct {
      word_type digest_word;
      logic     digest_last;
   } digest_beat_type;

   typedef struct {
      logic [7:0]   data_byte;
      logic         byte_present;
      logic         message_end;
      bit           known;
      logic [255:0] digest;
   } stim_row_type;

   localparam word_type ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_message_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;

   // Running hash state of the message being absorbed.
   word_type    chain_state [8];
   logic [7:0]  block_buf [64];
   logic [60:0] byte_count;

   digest_beat_type pending_digest_words [$];
   stim_row_type    directed_rows [$];

   int error_count = 0;
   int burst_left = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   int ready_mode = 0;
   int mode_cycles = 0;

   sha256_byte_stream_hasher_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_last  (rsp_digest_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic word_type rotr32(input word_type v, input int unsigned n);
      logic [63:0] both;
      both = {v, v} >> n;
      return both[31:0];
   endfunction

   function automatic void clear_hash_state();
      int i;
      for (i = 0; i < 8; i++) chain_state[i] = HASH_INIT[i];
      byte_count = '0;
   endfunction

   function automatic void compress_block();
      word_type sched [64];
      word_type v [8];
      word_type s0, s1, choose, major, t1, t2;
      int i;
      for (i = 0; i < 16; i++) begin
         sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
         s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      for (i = 0; i < 8; i++) v[i] = chain_state[i];
      for (i = 0; i < 64; i++) begin
         s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
         choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + choose + ROUND_CONST[i] + sched[i];
         s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
         major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2 = s0 + major;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) chain_state[i] = chain_state[i] + v[i];
   endfunction

   // Absorbs one transaction; returns 1 with the digest when the message ends.
   function automatic bit absorb_item(input logic [7:0] data_byte, input logic present,
                                      input logic msg_end, output logic [255:0] digest);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      int i;
      digest = '0;
      pos = byte_count[5:0];
      if (present) begin
         block_buf[pos] = data_byte;
         byte_count = byte_count + 61'd1;
         if (pos == 6'd63) compress_block();
      end
      if (!msg_end) return 1'b0;
      pos = byte_count[5:0];
      block_buf[pos] = 8'h80;
      for (i = int'(pos) + 1; i < 64; i++) block_buf[i] = 8'h00;
      // The length field does not fit behind the marker, so one more block is needed.
      if (pos >= 6'd56) begin
         compress_block();
         for (i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      bit_len = {byte_count, 3'b000};
      for (i = 0; i < 8; i++) block_buf[56+i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (i = 0; i < 8; i++) digest[255 - 32*i -: 32] = chain_state[i];
      clear_hash_state();
      return 1'b1;
   endfunction

   function automatic stim_row_type stim_row(input logic [7:0] data_byte, input logic present,
                                             input logic msg_end, input bit known,
                                             input logic [255:0] digest);
      stim_row_type row;
      row.data_byte = data_byte;
      row.byte_present = present;
      row.message_end = msg_end;
      row.known = known;
      row.digest = digest;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s: got %08h, expected %08h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input logic [7:0] data_byte, input logic present,
                            input logic msg_end, input bit known,
                            input logic [255:0] known_digest);
      int gap;
      int k;
      logic [255:0] digest;
      digest_beat_type beat;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= data_byte;
      req_byte_present <= present;
      req_message_end <= msg_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (absorb_item(data_byte, present, msg_end, digest)) begin
         if (known) digest = known_digest;
         for (k = 0; k < 8; k++) begin
            beat.digest_word = digest[255 - 32*k -: 32];
            beat.digest_last = (k == 7);
            pending_digest_words = {pending_digest_words, beat};
         end
      end
   endtask

   // Random bytes with an occasional empty transaction mixed in; the end marker
   // rides on the last byte or on a separate empty transaction.
   task automatic send_message(input int len);
      bit end_on_byte;
      int k;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0, '0);
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == len - 1), 0, '0);
      end
      if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 0, '0);
   endtask

   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 200);
      end
      mode_cycles--;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digest_words.size() == 0) begin
            report_mismatch("digest word with none pending", rsp_digest_word, '0);
         end else begin
            want = pending_digest_words.pop_front();
            if (rsp_digest_word !== want.digest_word) begin
               report_mismatch("digest_word", rsp_digest_word, want.digest_word);
            end
            if (rsp_digest_last !== want.digest_last) begin
               report_mismatch("digest_last", {31'b0, rsp_digest_last}, {31'b0, want.digest_last});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int len;
      clear_hash_state();

      directed_rows = {directed_rows, stim_row(8'h5a, 1'b0, 1'b1, 1, EMPTY_DIGEST)};
      directed_rows = {directed_rows, stim_row(8'hff, 1'b0, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h61, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h62, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h63, 1'b1, 1'b1, 1, ABC_DIGEST)};
      directed_rows = {directed_rows, stim_row(8'h00, 1'b0, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h00, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'hff, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h80, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h7f, 1'b1, 1'b0, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'hff, 1'b0, 1'b1, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'hff, 1'b1, 1'b1, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h00, 1'b1, 1'b1, 0, '0)};
      directed_rows = {directed_rows, stim_row(8'h00, 1'b0, 1'b1, 1, EMPTY_DIGEST)};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_rows.size(); r++) begin
         send_item(directed_rows[r].data_byte, directed_rows[r].byte_present,
                   directed_rows[r].message_end, directed_rows[r].known,
                   directed_rows[r].digest);
      end

      // Fifty-six bytes force a second padding block; sixty-four fill a block first.
      send_message(56);
      send_message(64);
      while (items_sent < TOTAL_ITEMS) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
         send_message(len);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_digest_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sha256_byte_stream_hasher_unit.f @@
design/shabsh_pkg.sv
design/shabsh_ctrl.sv
design/shabsh_dp.sv
design/sha256_byte_stream_hasher_unit.sv
design/shabsh_checker.sv
test/sha256_byte_stream_hasher_unit_test.sv
